// ===== design/rcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfd_pkg
// Types and constants shared by the radar channel frame deframer modules.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    // frame and channel heads
    localparam logic [31:0] FRAME_HEAD = 32'h0123_4567;
    localparam logic [31:0] CHAN_HEAD  = 32'hEB90_A55A;

    // byte counter saturates at its all-ones value
    localparam int          COUNT_W   = 21;
    localparam logic [20:0] COUNT_MAX = 21'h1F_FFFF;

    // byte offset of the last frame head byte
    localparam logic [20:0] FRAME_HEAD_LAST = 21'd3;

    // field counts inside a channel
    localparam logic [15:0] CHAN_HEAD_BYTES  = 16'd4;
    localparam logic [15:0] START_DONE_BYTES = 16'd4;
    localparam logic [15:0] CHAN_INFO_BYTES  = 16'd6;
    localparam logic [15:0] AFTER_BYTES      = 16'd4;

    // fixed bytes per channel used by the expected-length check
    localparam int CHAN_FIXED_BYTES   = 10;
    localparam int SECOND_FIXED_BYTES = 4;
    localparam int EXPECT_W           = 24;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    // result kinds
    localparam logic RESULT_SAMPLE = 1'b0;
    localparam logic RESULT_STATUS = 1'b1;

    // frame status and error codes
    localparam logic [2:0] ST_OK             = 3'd0;
    localparam logic [2:0] ST_BAD_HEAD       = 3'd1;
    localparam logic [2:0] ST_BAD_FIRST_CHAN = 3'd2;
    localparam logic [2:0] ST_LEN_MISMATCH   = 3'd3;
    localparam logic [2:0] ST_BAD_LATER_CHAN = 3'd4;

    // parse phases, in frame order
    typedef enum logic [3:0] {
        PH_HDR    = 4'd0,
        PH_CHHEAD = 4'd1,
        PH_CHINFO = 4'd2,
        PH_F_HI   = 4'd3,
        PH_F_LO   = 4'd4,
        PH_AFTER  = 4'd5,
        PH_S_HI   = 4'd6,
        PH_S_LO   = 4'd7,
        PH_SKIP   = 4'd8,
        PH_DONE   = 4'd9
    } rcfd_phase_t;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [1:0]  channel;
        logic        segment;
        logic [16:0] position;
        logic [15:0] value;
        logic        last;
        logic [15:0] peak;
        logic [2:0]  status;
    } rcfd_result_t;

    // results produced by one input item, first slot filled first
    typedef struct packed {
        logic [1:0]   count;
        rcfd_result_t first;
        rcfd_result_t second;
    } rcfd_push_t;

endpackage

// ===== design/rcfd_parser.sv =====
// ----------------------------------------------------------------------------
// rcfd_parser
// Frame parse state and per-byte result generation for the deframer.
// ----------------------------------------------------------------------------
module rcfd_parser
    import rcfd_pkg::*;
#(
    parameter int HEADER_BYTES = 88,
    parameter int CHANNELS     = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       frame_end,
    output rcfd_push_t push
);

    localparam logic [21:0] HDR_END    = 22'(HEADER_BYTES);
    localparam logic [3:0]  CHAN_COUNT = 4'(CHANNELS);

    // parse state
    logic [20:0]  byte_count_reg, byte_count_next;
    rcfd_phase_t  phase_reg, phase_next;
    logic [15:0]  field_count_reg, field_count_next;
    logic [15:0]  first_start_reg, first_start_next;
    logic [15:0]  first_length_reg, first_length_next;
    logic [15:0]  second_start_reg, second_start_next;
    logic [15:0]  second_length_reg, second_length_next;
    logic [31:0]  recent_reg, recent_next;
    logic [2:0]   chan_reg, chan_next;
    logic [15:0]  peak_value_reg, peak_value_next;
    logic [15:0]  peak_pos_reg, peak_pos_next;
    logic [2:0]   error_reg, error_next;

    // sample datapath
    logic [31:0]  shifted;
    logic [15:0]  samp_val;
    logic [15:0]  fc_inc;
    logic         take_peak;
    logic [15:0]  samp_peak_val;
    logic [15:0]  samp_peak_pos;
    logic [15:0]  seg_len;
    logic [15:0]  seg_start;
    logic         seg_last;
    logic         sample_emit;
    logic         last_chan;

    // status path
    logic [EXPECT_W-1:0] expected_bytes;
    logic                short_frame;
    logic                mismatch;
    logic [2:0]          status;
    rcfd_result_t        sample_res;
    rcfd_result_t        status_res;

    assign shifted       = {recent_reg[23:0], data_byte};
    assign samp_val      = shifted[15:0];
    assign fc_inc        = field_count_reg + 16'd1;
    assign take_peak     = (field_count_reg == 16'd0) || (samp_val > peak_value_reg);
    assign samp_peak_val = take_peak ? samp_val : peak_value_reg;
    assign samp_peak_pos = take_peak ? field_count_reg : peak_pos_reg;
    assign seg_len       = (phase_reg == PH_S_LO) ? second_length_reg : first_length_reg;
    assign seg_start     = (phase_reg == PH_S_LO) ? second_start_reg : first_start_reg;
    assign seg_last      = (fc_inc >= seg_len);
    assign sample_emit   = fire && ((phase_reg == PH_F_LO) || (phase_reg == PH_S_LO));
    assign last_chan     = (({1'b0, chan_reg} + 4'd1) >= CHAN_COUNT);

    // next state of the parse for one byte
    always_comb
    begin
        byte_count_next    = byte_count_reg;
        phase_next         = phase_reg;
        field_count_next   = field_count_reg;
        first_start_next   = first_start_reg;
        first_length_next  = first_length_reg;
        second_start_next  = second_start_reg;
        second_length_next = second_length_reg;
        recent_next        = shifted;
        chan_next          = chan_reg;
        peak_value_next    = peak_value_reg;
        peak_pos_next      = peak_pos_reg;
        error_next         = error_reg;

        if (byte_count_reg < COUNT_MAX)
        begin
            byte_count_next = byte_count_reg + 21'd1;
        end

        case (phase_reg)
            PH_HDR:
            begin
                if (byte_count_reg == FRAME_HEAD_LAST && shifted != FRAME_HEAD)
                begin
                    error_next = ST_BAD_HEAD;
                    phase_next = PH_SKIP;
                end
                else if (({1'b0, byte_count_reg} + 22'd1) >= HDR_END)
                begin
                    phase_next       = PH_CHHEAD;
                    field_count_next = 16'd0;
                end
            end
            PH_CHHEAD:
            begin
                field_count_next = fc_inc;
                if (fc_inc >= CHAN_HEAD_BYTES)
                begin
                    field_count_next = 16'd0;
                    if (shifted != CHAN_HEAD)
                    begin
                        error_next = (chan_reg == 3'd0) ? ST_BAD_FIRST_CHAN
                                                        : ST_BAD_LATER_CHAN;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_CHINFO;
                    end
                end
            end
            PH_CHINFO:
            begin
                field_count_next = fc_inc;
                if (fc_inc == START_DONE_BYTES && chan_reg == 3'd0)
                begin
                    first_start_next = shifted[15:0];
                end
                if (fc_inc >= CHAN_INFO_BYTES)
                begin
                    if (chan_reg == 3'd0)
                    begin
                        first_length_next = shifted[15:0];
                    end
                    field_count_next = 16'd0;
                    phase_next = (first_length_next == 16'd0) ? PH_AFTER : PH_F_HI;
                end
            end
            PH_F_HI:
            begin
                phase_next = PH_F_LO;
            end
            PH_F_LO:
            begin
                peak_value_next = samp_peak_val;
                peak_pos_next   = samp_peak_pos;
                if (seg_last)
                begin
                    field_count_next = 16'd0;
                    phase_next       = PH_AFTER;
                end
                else
                begin
                    field_count_next = fc_inc;
                    phase_next       = PH_F_HI;
                end
            end
            PH_AFTER:
            begin
                field_count_next = fc_inc;
                if (fc_inc >= AFTER_BYTES)
                begin
                    field_count_next = 16'd0;
                    if (shifted == CHAN_HEAD)
                    begin
                        if (chan_reg == 3'd0)
                        begin
                            second_start_next  = 16'd0;
                            second_length_next = 16'd0;
                        end
                        if (last_chan)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            chan_next  = chan_reg + 3'd1;
                            phase_next = PH_CHINFO;
                        end
                    end
                    else
                    begin
                        if (chan_reg == 3'd0)
                        begin
                            second_start_next  = shifted[31:16];
                            second_length_next = shifted[15:0];
                        end
                        if (second_length_next != 16'd0)
                        begin
                            phase_next = PH_S_HI;
                        end
                        else if (last_chan)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            chan_next  = chan_reg + 3'd1;
                            phase_next = PH_CHHEAD;
                        end
                    end
                end
            end
            PH_S_HI:
            begin
                phase_next = PH_S_LO;
            end
            PH_S_LO:
            begin
                peak_value_next = samp_peak_val;
                peak_pos_next   = samp_peak_pos;
                if (seg_last)
                begin
                    field_count_next = 16'd0;
                    if (last_chan)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        chan_next  = chan_reg + 3'd1;
                        phase_next = PH_CHHEAD;
                    end
                end
                else
                begin
                    field_count_next = fc_inc;
                    phase_next       = PH_S_HI;
                end
            end
            default:
            begin
            end
        endcase
    end

    // end-of-frame status from the state after this byte
    always_comb
    begin
        expected_bytes = EXPECT_W'(HEADER_BYTES)
            + EXPECT_W'(CHANNELS) * (({8'd0, first_length_next} << 1)
                                     + EXPECT_W'(CHAN_FIXED_BYTES));
        if (second_length_next != 16'd0)
        begin
            expected_bytes = expected_bytes
                + EXPECT_W'(CHANNELS) * (({8'd0, second_length_next} << 1)
                                         + EXPECT_W'(SECOND_FIXED_BYTES));
        end

        short_frame = (chan_next == 3'd0)
                   && ((phase_next == PH_HDR)   || (phase_next == PH_CHHEAD)
                    || (phase_next == PH_CHINFO) || (phase_next == PH_F_HI)
                    || (phase_next == PH_F_LO)   || (phase_next == PH_AFTER));
        mismatch = (byte_count_next == COUNT_MAX)
                || ({3'd0, byte_count_next} != expected_bytes);

        if (error_next == ST_BAD_HEAD || error_next == ST_BAD_FIRST_CHAN)
        begin
            status = error_next;
        end
        else if (short_frame)
        begin
            status = ST_BAD_HEAD;
        end
        else if (mismatch)
        begin
            status = ST_LEN_MISMATCH;
        end
        else if (error_next == ST_BAD_LATER_CHAN)
        begin
            status = ST_BAD_LATER_CHAN;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // result items for this byte
    always_comb
    begin
        sample_res.kind     = RESULT_SAMPLE;
        sample_res.channel  = chan_reg[1:0];
        sample_res.segment  = (phase_reg == PH_S_LO);
        sample_res.position = {1'b0, seg_start} + {1'b0, field_count_reg};
        sample_res.value    = samp_val;
        sample_res.last     = seg_last;
        sample_res.peak     = seg_last ? samp_peak_pos : 16'd0;
        sample_res.status   = ST_OK;

        status_res          = '0;
        status_res.kind     = RESULT_STATUS;
        status_res.status   = status;

        push.first  = sample_emit ? sample_res : status_res;
        push.second = status_res;
        push.count  = {1'b0, sample_emit} + {1'b0, fire && frame_end};
    end

    // state registers, back to reset after the last byte of a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            phase_reg         <= PH_HDR;
            field_count_reg   <= '0;
            first_start_reg   <= '0;
            first_length_reg  <= '0;
            second_start_reg  <= '0;
            second_length_reg <= '0;
            recent_reg        <= '0;
            chan_reg          <= '0;
            peak_value_reg    <= '0;
            peak_pos_reg      <= '0;
            error_reg         <= ST_OK;
        end
        else if (fire)
        begin
            if (frame_end)
            begin
                byte_count_reg    <= '0;
                phase_reg         <= PH_HDR;
                field_count_reg   <= '0;
                first_start_reg   <= '0;
                first_length_reg  <= '0;
                second_start_reg  <= '0;
                second_length_reg <= '0;
                recent_reg        <= '0;
                chan_reg          <= '0;
                peak_value_reg    <= '0;
                peak_pos_reg      <= '0;
                error_reg         <= ST_OK;
            end
            else
            begin
                byte_count_reg    <= byte_count_next;
                phase_reg         <= phase_next;
                field_count_reg   <= field_count_next;
                first_start_reg   <= first_start_next;
                first_length_reg  <= first_length_next;
                second_start_reg  <= second_start_next;
                second_length_reg <= second_length_next;
                recent_reg        <= recent_next;
                chan_reg          <= chan_next;
                peak_value_reg    <= peak_value_next;
                peak_pos_reg      <= peak_pos_next;
                error_reg         <= error_next;
            end
        end
    end

endmodule

// ===== design/rcfd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// rcfd_result_fifo
// Small result queue taking up to two items per cycle, giving one on out_ready.
// ----------------------------------------------------------------------------
module rcfd_result_fifo
    import rcfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rcfd_push_t   push,
    input  logic         out_ready,
    output logic         out_valid,
    output rcfd_result_t head,
    output logic         room
);

    rcfd_result_t               mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]       count_reg, count_next;
    logic                       pop;

    assign out_valid = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // space for the two items a single byte may bring
    assign room      = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + RES_CNT_W'(push.count) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + RES_PTR_W'(1)] <= push.second;
        end
    end

endmodule

// ===== design/radar_channel_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// radar_channel_frame_deframer_top
// Byte-wise radar frame deframer: emits samples per segment and frame status.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the input register until the result queue
// has room, is parsed into the queue and is offered from the queue head.
// Throughput: one byte per cycle while the queue has room; a byte carrying
// a sample and the frame status puts two items into the 4-entry result queue.
// Reset: rst_n asynchronous, clears parse state and the queue at once.
// ----------------------------------------------------------------------------
module radar_channel_frame_deframer_top
    import rcfd_pkg::*;
#(
    parameter int HEADER_BYTES = 88,
    parameter int CHANNELS     = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [1:0]  channel_number,
    output logic        segment_number,
    output logic [16:0] sample_position,
    output logic [15:0] sample_value,
    output logic        segment_last,
    output logic [15:0] peak_index,
    output logic [2:0]  frame_status
);

    logic         stage_valid_reg;
    logic [7:0]   stage_byte_reg;
    logic         stage_end_reg;
    logic         stage_fire;
    logic         room;
    rcfd_push_t   push;
    rcfd_result_t head;

    // input register
    assign stage_fire = stage_valid_reg && room;
    assign in_ready   = !stage_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (stage_fire)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_byte_reg <= data_byte;
            stage_end_reg  <= frame_end;
        end
    end

    // frame parser
    rcfd_parser #(
        .HEADER_BYTES (HEADER_BYTES),
        .CHANNELS     (CHANNELS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (stage_fire),
        .data_byte (stage_byte_reg),
        .frame_end (stage_end_reg),
        .push      (push)
    );

    // result queue
    rcfd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .room      (room)
    );

    assign result_kind     = head.kind;
    assign channel_number  = head.channel;
    assign segment_number  = head.segment;
    assign sample_position = head.position;
    assign sample_value    = head.value;
    assign segment_last    = head.last;
    assign peak_index      = head.peak;
    assign frame_status    = head.status;

    // status items carry nothing but their status
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RESULT_STATUS |->
            channel_number == 2'd0 && segment_number == 1'b0
            && sample_position == 17'd0 && sample_value == 16'd0
            && segment_last == 1'b0 && peak_index == 16'd0)
        else $error("status item with nonzero sample fields");

    // sample items report ok status and a peak only at segment end
    a_sample_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RESULT_SAMPLE |->
            frame_status == ST_OK && (segment_last || peak_index == 16'd0))
        else $error("sample item with status or early peak");

    // two items from one byte only when the second is the frame status
    a_double_push: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |->
            push.first.kind == RESULT_SAMPLE && push.second.kind == RESULT_STATUS)
        else $error("bad double push");

    // parser only produces items for a byte it takes
    a_push_fire: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> stage_fire)
        else $error("push without a byte");

endmodule

// ===== tb/sv/radar_channel_frame_deframer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_channel_frame_deframer_checker
// Watches both channels of the deframer. Every accepted byte is run through
// a local deframing model that queues the samples and frame status it
// should produce. Every accepted result is compared field by field with the
// oldest queued one. The mismatch count and the number of results still
// owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module radar_channel_frame_deframer_checker
    import rcfd_pkg::*;
#(
    parameter int HEADER_BYTES = 88,
    parameter int CHANNELS     = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        result_kind,
    input  logic [1:0]  channel_number,
    input  logic        segment_number,
    input  logic [16:0] sample_position,
    input  logic [15:0] sample_value,
    input  logic        segment_last,
    input  logic [15:0] peak_index,
    input  logic [2:0]  frame_status,
    output int          mismatch_count,
    output int          outstanding,
    output int          compared
);

    // local copy of the parse state
    rcfd_phase_t  phase;
    logic [20:0]  byte_cnt;
    logic [15:0]  field_cnt;
    logic [15:0]  seg1_start;
    logic [15:0]  seg1_len;
    logic [15:0]  seg2_start;
    logic [15:0]  seg2_len;
    logic [31:0]  recent;
    logic [2:0]   chan_idx;
    logic [15:0]  peak_val;
    logic [15:0]  peak_pos;
    logic [2:0]   err_code;

    // samples and status words the block still owes
    rcfd_result_t deframed_q[$];

    int errs;
    int seen;

    task automatic clear_parse();
        byte_cnt   = '0;
        phase      = PH_HDR;
        field_cnt  = '0;
        seg1_start = '0;
        seg1_len   = '0;
        seg2_start = '0;
        seg2_len   = '0;
        recent     = '0;
        chan_idx   = '0;
        peak_val   = '0;
        peak_pos   = '0;
        err_code   = ST_OK;
    endtask

    // move on to the next channel, or stop once the last one is done
    task automatic advance_channel(input rcfd_phase_t target);
        field_cnt = '0;
        if (int'(chan_idx) + 1 >= CHANNELS)
            phase = PH_DONE;
        else
        begin
            chan_idx = chan_idx + 3'd1;
            phase    = target;
        end
    endtask

    // one completed big-endian sample, peak tracked on values
    task automatic take_sample(input logic seg, input logic [15:0] start,
                               input logic [15:0] len, output logic seg_done);
        rcfd_result_t r;
        logic [15:0]  idx;
        idx = field_cnt;
        if (idx == 16'd0 || recent[15:0] > peak_val)
        begin
            peak_val = recent[15:0];
            peak_pos = idx;
        end
        field_cnt  = field_cnt + 16'd1;
        seg_done   = (field_cnt >= len);
        r          = '0;
        r.kind     = RESULT_SAMPLE;
        r.channel  = chan_idx[1:0];
        r.segment  = seg;
        r.position = {1'b0, start} + {1'b0, idx};
        r.value    = recent[15:0];
        r.last     = seg_done;
        r.peak     = seg_done ? peak_pos : 16'd0;
        r.status   = ST_OK;
        deframed_q.push_back(r);
    endtask

    // advance the frame parse by one byte
    task automatic deframe_byte(input logic [7:0] b, input logic fe);
        logic [20:0]  pos;
        logic         seg_done;
        logic         short_frame;
        logic [2:0]   st;
        longint       want_len;
        rcfd_result_t r;
        pos    = byte_cnt;
        recent = {recent[23:0], b};
        if (byte_cnt != COUNT_MAX)
            byte_cnt = byte_cnt + 21'd1;

        case (phase)
            PH_HDR:
            begin
                if (pos == FRAME_HEAD_LAST && recent != FRAME_HEAD)
                begin
                    err_code = ST_BAD_HEAD;
                    phase    = PH_SKIP;
                end
                else if (int'(pos) + 1 >= HEADER_BYTES)
                begin
                    phase     = PH_CHHEAD;
                    field_cnt = '0;
                end
            end
            PH_CHHEAD:
            begin
                field_cnt = field_cnt + 16'd1;
                if (field_cnt >= CHAN_HEAD_BYTES)
                begin
                    field_cnt = '0;
                    if (recent != CHAN_HEAD)
                    begin
                        err_code = (chan_idx == 3'd0) ? ST_BAD_FIRST_CHAN : ST_BAD_LATER_CHAN;
                        phase    = PH_SKIP;
                    end
                    else
                        phase = PH_CHINFO;
                end
            end
            PH_CHINFO:
            begin
                // channel number, then segment start and length
                field_cnt = field_cnt + 16'd1;
                if (field_cnt == START_DONE_BYTES && chan_idx == 3'd0)
                    seg1_start = recent[15:0];
                if (field_cnt >= CHAN_INFO_BYTES)
                begin
                    if (chan_idx == 3'd0)
                        seg1_len = recent[15:0];
                    field_cnt = '0;
                    phase     = (seg1_len == 16'd0) ? PH_AFTER : PH_F_HI;
                end
            end
            PH_F_HI:
                phase = PH_F_LO;
            PH_F_LO:
            begin
                take_sample(1'b0, seg1_start, seg1_len, seg_done);
                if (seg_done)
                begin
                    field_cnt = '0;
                    phase     = PH_AFTER;
                end
                else
                    phase = PH_F_HI;
            end
            PH_AFTER:
            begin
                // either the next channel head or the second segment settings
                field_cnt = field_cnt + 16'd1;
                if (field_cnt >= AFTER_BYTES)
                begin
                    field_cnt = '0;
                    if (recent == CHAN_HEAD)
                    begin
                        if (chan_idx == 3'd0)
                        begin
                            seg2_start = '0;
                            seg2_len   = '0;
                        end
                        advance_channel(PH_CHINFO);
                    end
                    else
                    begin
                        if (chan_idx == 3'd0)
                        begin
                            seg2_start = recent[31:16];
                            seg2_len   = recent[15:0];
                        end
                        if (seg2_len == 16'd0)
                            advance_channel(PH_CHHEAD);
                        else
                            phase = PH_S_HI;
                    end
                end
            end
            PH_S_HI:
                phase = PH_S_LO;
            PH_S_LO:
            begin
                take_sample(1'b1, seg2_start, seg2_len, seg_done);
                if (seg_done)
                    advance_channel(PH_CHHEAD);
                else
                    phase = PH_S_HI;
            end
            default:
                ;
        endcase

        // status word on the last byte, then back to a fresh frame
        if (fe)
        begin
            want_len = HEADER_BYTES
                     + CHANNELS * (CHAN_FIXED_BYTES + 2 * longint'(seg1_len));
            if (seg2_len != 16'd0)
                want_len += CHANNELS * (SECOND_FIXED_BYTES + 2 * longint'(seg2_len));
            short_frame = (chan_idx == 3'd0) && (phase <= PH_AFTER);
            if (err_code == ST_BAD_HEAD || err_code == ST_BAD_FIRST_CHAN)
                st = err_code;
            else if (short_frame)
                st = ST_BAD_HEAD;
            else if (byte_cnt == COUNT_MAX || longint'(byte_cnt) != want_len)
                st = ST_LEN_MISMATCH;
            else if (err_code == ST_BAD_LATER_CHAN)
                st = ST_BAD_LATER_CHAN;
            else
                st = ST_OK;
            r        = '0;
            r.kind   = RESULT_STATUS;
            r.status = st;
            deframed_q.push_back(r);
            clear_parse();
        end
    endtask

    function automatic int field_differs(input string name, input int want_v,
                                         input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                     $time, name, want_v, want_v, got_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    // model on accepted bytes, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        rcfd_result_t want;
        int           wrong;
        if (!rst_n)
        begin
            clear_parse();
            deframed_q.delete();
            errs = 0;
            seen = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                deframe_byte(data_byte, frame_end);

            if (out_valid && out_ready)
            begin
                if (deframed_q.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected, got kind %0d ch %0d seg %0d pos %0d value 0x%0h last %0d peak %0d status %0d",
                             $time, result_kind, channel_number, segment_number,
                             sample_position, sample_value, segment_last, peak_index,
                             frame_status);
                    errs++;
                end
                else
                begin
                    want  = deframed_q.pop_front();
                    wrong = 0;
                    wrong += field_differs("result_kind", want.kind, result_kind);
                    wrong += field_differs("channel_number", want.channel, channel_number);
                    wrong += field_differs("segment_number", want.segment, segment_number);
                    wrong += field_differs("sample_position", want.position,
                                           sample_position);
                    wrong += field_differs("sample_value", want.value, sample_value);
                    wrong += field_differs("segment_last", want.last, segment_last);
                    wrong += field_differs("peak_index", want.peak, peak_index);
                    wrong += field_differs("frame_status", want.status, frame_status);
                    if (wrong != 0)
                        errs++;
                    seen++;
                end
            end
        end
        mismatch_count <= errs;
        outstanding    <= deframed_q.size();
        compared       <= seen;
    end

endmodule

// ===== tb/sv/tb_radar_channel_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radar_channel_frame_deframer_top
// Feeds radar frames byte by byte into the deframer: a few short directed
// frames, one frame of every shape, then random frames, half of them well
// formed with random segment sizes and sample data, the rest damaged in
// head, length or segment layout. Both sides idle at random and the output
// is once held off long enough to back the block up. The checker beside the
// block does all predicting and comparing.
// ----------------------------------------------------------------------------
module tb_radar_channel_frame_deframer_top
    import rcfd_pkg::*;
();

    localparam int HEADER_BYTES   = 88;
    localparam int CHANNELS       = 4;
    localparam int TARGET_BYTES   = 1850;
    localparam int HOLD_AT_RESULT = 150;
    localparam int HOLD_CYCLES    = 200;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 16;

    // ways a generated frame is laid out or damaged
    typedef enum int {
        FR_CLEAN,
        FR_BAD_FRAME_HEAD,
        FR_BAD_FIRST_CHAN,
        FR_BAD_LATER_CHAN,
        FR_CUT_SHORT,
        FR_EXTRA_BYTES,
        FR_ZERO_SECOND,
        FR_MISSING_SECOND
    } frame_shape_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic        out_valid;
    logic        out_ready;
    logic        result_kind;
    logic [1:0]  channel_number;
    logic        segment_number;
    logic [16:0] sample_position;
    logic [15:0] sample_value;
    logic        segment_last;
    logic [15:0] peak_index;
    logic [2:0]  frame_status;

    int mismatch_count;
    int outstanding;
    int compared;

    logic [7:0] frame_bytes[$];
    bit         tie_values;
    bit         sender_calm;
    int         bytes_sent;
    int         frames_sent;
    int         idle_cycles;

    radar_channel_frame_deframer_top #(
        .HEADER_BYTES (HEADER_BYTES),
        .CHANNELS     (CHANNELS)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .frame_end       (frame_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .channel_number  (channel_number),
        .segment_number  (segment_number),
        .sample_position (sample_position),
        .sample_value    (sample_value),
        .segment_last    (segment_last),
        .peak_index      (peak_index),
        .frame_status    (frame_status)
    );

    radar_channel_frame_deframer_checker #(
        .HEADER_BYTES (HEADER_BYTES),
        .CHANNELS     (CHANNELS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .frame_end       (frame_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .channel_number  (channel_number),
        .segment_number  (segment_number),
        .sample_position (sample_position),
        .sample_value    (sample_value),
        .segment_last    (segment_last),
        .peak_index      (peak_index),
        .frame_status    (frame_status),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .compared        (compared)
    );

    // 125 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // big-endian bytes of a word
    task automatic push_be(input logic [31:0] w, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            frame_bytes.push_back(w[8*i +: 8]);
    endtask

    // ties on the extremes now and then so the first maximum matters
    function automatic logic [15:0] sample_word();
        logic [15:0] ties[4];
        ties = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001};
        if (tie_values)
            return ties[$urandom_range(3, 0)];
        return 16'($urandom);
    endfunction

    // starts near the top make the position carry into bit 16
    function automatic logic [15:0] pick_start();
        if ($urandom_range(3, 0) == 0)
            return 16'hFFFF - 16'($urandom_range(3, 0));
        return 16'($urandom);
    endfunction

    function automatic frame_shape_t pick_shape();
        case ($urandom_range(15, 0))
            8:       return FR_BAD_FRAME_HEAD;
            9:       return FR_BAD_FIRST_CHAN;
            10:      return FR_BAD_LATER_CHAN;
            11, 12:  return FR_CUT_SHORT;
            13:      return FR_EXTRA_BYTES;
            14:      return FR_ZERO_SECOND;
            15:      return FR_MISSING_SECOND;
            default: return FR_CLEAN;
        endcase
    endfunction

    // lay out one frame in frame_bytes
    task automatic build_frame(input int len1, input int len2, input frame_shape_t shape);
        int          bad_chan;
        int          skip_second;
        int          cut;
        logic [15:0] start1;
        logic [15:0] start2;
        frame_bytes.delete();
        tie_values  = ($urandom_range(3, 0) == 0);
        start1      = pick_start();
        start2      = pick_start();
        bad_chan    = -1;
        skip_second = -1;
        if (shape == FR_BAD_LATER_CHAN)
            bad_chan = $urandom_range(CHANNELS - 1, 1);
        if (shape == FR_MISSING_SECOND)
            skip_second = $urandom_range(CHANNELS - 1, 1);

        // a bad frame or first channel head leaves the rest ignored, keep it short
        if (shape == FR_BAD_FRAME_HEAD)
        begin
            push_be(FRAME_HEAD ^ (32'd1 << $urandom_range(31, 0)), 4);
            repeat ($urandom_range(6, 0)) frame_bytes.push_back(8'($urandom));
            return;
        end
        push_be(FRAME_HEAD, 4);
        repeat (HEADER_BYTES - 4) frame_bytes.push_back(8'($urandom));
        if (shape == FR_BAD_FIRST_CHAN)
        begin
            push_be(CHAN_HEAD ^ (32'd1 << $urandom_range(31, 0)), 4);
            repeat ($urandom_range(6, 0)) frame_bytes.push_back(8'($urandom));
            return;
        end

        // later channels carry random settings, only channel 0 counts
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (ch == bad_chan)
                push_be(CHAN_HEAD ^ (32'd1 << $urandom_range(31, 0)), 4);
            else
                push_be(CHAN_HEAD, 4);
            push_be(32'($urandom), 2);
            push_be(ch == 0 ? start1 : 16'($urandom), 2);
            push_be(ch == 0 ? 16'(len1) : 16'($urandom), 2);
            repeat (len1) push_be(sample_word(), 2);
            if (shape == FR_ZERO_SECOND)
            begin
                push_be(32'($urandom), 2);
                push_be(32'd0, 2);
            end
            else if (len2 != 0 && ch != skip_second)
            begin
                push_be(ch == 0 ? start2 : 16'($urandom), 2);
                push_be(ch == 0 ? 16'(len2) : 16'($urandom), 2);
                repeat (len2) push_be(sample_word(), 2);
            end
        end

        if (shape == FR_EXTRA_BYTES)
            repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom));
        if (shape == FR_CUT_SHORT)
        begin
            // half the time one to three bytes off the end, else a cut anywhere in the frame
            if ($urandom_range(1, 0) == 0)
                cut = $urandom_range(3, 1);
            else
                cut = $urandom_range(frame_bytes.size() - 1, 1);
            repeat (cut) void'(frame_bytes.pop_back());
        end
    endtask

    // one item on the input channel, after a random wait
    task automatic send_byte(input logic [7:0] b, input logic fe);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(15, 0);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        frame_end <= fe;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        sender_calm = ($urandom_range(3, 0) == 0);
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    // stimulus and verdict
    initial
    begin
        frame_shape_t shape;
        int           len1;
        int           len2;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        data_byte   <= 8'h00;
        frame_end   <= 1'b0;
        bytes_sent  = 0;
        frames_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone byte, head only, bad heads with extreme bytes after them
        frame_bytes = '{8'hFF};
        send_frame();
        frame_bytes = '{8'h01, 8'h23, 8'h45, 8'h67};
        send_frame();
        frame_bytes = '{8'h01, 8'h23, 8'h45, 8'h66, 8'hFF, 8'h00, 8'hA5};
        send_frame();
        frame_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F};
        send_frame();

        // every frame shape once, then empty segments
        shape = shape.first();
        do
        begin
            build_frame(3, 2, shape);
            send_frame();
            shape = shape.next();
        end
        while (shape != shape.first());
        build_frame(0, 0, FR_CLEAN);
        send_frame();
        build_frame(0, 1, FR_CLEAN);
        send_frame();

        // random frames, half of them well formed, mostly small
        while (bytes_sent < TARGET_BYTES)
        begin
            len1 = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 6) : $urandom_range(4, 0);
            len2 = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(3, 1);
            build_frame(len1, len2, pick_shape());
            send_frame();
        end
        in_valid <= 1'b0;

        // let the last results drain, once the checker has seen the last byte
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d frames in %0d bytes, %0d results compared",
                 frames_sent, bytes_sent, compared);
        $display("shapes: clean, bad heads, cut short, padded, zero and missing second segments");
        if (mismatch_count == 0)
            $display("tb_radar_channel_frame_deframer_top: done, clean");
        else
            $display("tb_radar_channel_frame_deframer_top: done, errors");
        $finish;
    end

    // result side: random waits, calm stretches and one long hold-off
    initial
    begin
        int gap;
        int taken;
        bit calm;
        bit held;
        taken     = 0;
        calm      = 1'b0;
        held      = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 48 == 0)
                calm = ($urandom_range(3, 0) == 0);
            gap = calm ? 0 : $urandom_range(15, 0);
            if (!held && taken == HOLD_AT_RESULT)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no item moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, outstanding);
            $display("tb_radar_channel_frame_deframer_top: done, errors");
            $finish;
        end
    end

endmodule
